@@ src/adsr_pkg.sv @@
package adsr_pkg;

	// fixed field widths
	localparam int ELAPSED_BITS = 20;
	localparam int TIME_W       = 12;
	localparam int LEVEL_W      = 11;
	localparam int PROD_W       = LEVEL_W + TIME_W;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 12;

	// full scale of the envelope gain
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(1024);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DECAY   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = CFG_IDX_W'(3);

	// reset values
	localparam logic [TIME_W-1:0]  ATTACK_RST  = TIME_W'(115);
	localparam logic [TIME_W-1:0]  DECAY_RST   = TIME_W'(200);
	localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(1020);
	localparam logic [TIME_W-1:0]  RELEASE_RST = TIME_W'(540);

	// payload carried along the divider chain
	typedef struct packed {
		logic [TIME_W-1:0]  rem;    // partial remainder, below den unless forced
		logic [LEVEL_W-1:0] nq;     // numerator bits still to enter / quotient bits
		logic [TIME_W-1:0]  den;    // divisor
		logic               forced; // level settled without division
		logic [LEVEL_W-1:0] fval;   // settled level
		logic               sub;    // decay: level is full scale minus quotient
		logic               rel;    // releasing flag of the beat
	} div_beat_t;

endpackage

@@ src/adsr_prep.sv @@
module adsr_prep (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic [adsr_pkg::ELAPSED_BITS-1:0]   elapsed_ms,
	input  logic                                releasing,
	input  logic [adsr_pkg::ELAPSED_BITS-1:0]   release_elapsed_ms,
	input  logic [adsr_pkg::TIME_W-1:0]         attack_ms,
	input  logic [adsr_pkg::TIME_W-1:0]         decay_ms,
	input  logic [adsr_pkg::LEVEL_W-1:0]        sustain_level,
	input  logic [adsr_pkg::TIME_W-1:0]         release_ms,
	output logic                                out_vld,
	output adsr_pkg::div_beat_t                 out_beat
);
	import adsr_pkg::*;

	localparam int EXT_W = ELAPSED_BITS - TIME_W;

	typedef struct packed {
		logic [LEVEL_W-1:0] m;
		logic [TIME_W-1:0]  x;
		logic [TIME_W-1:0]  den;
		logic               forced;
		logic [LEVEL_W-1:0] fval;
		logic               sub;
		logic               rel;
	} setup_t;

	logic [TIME_W:0]     ad_sum;
	logic                in_attack;
	logic                in_decay;
	logic                rel_over;
	setup_t              setup;
	setup_t              setup_s1;
	logic                vld_s1;
	logic [PROD_W-1:0]   prod;
	div_beat_t           beat_s2;
	logic                vld_s2;

	// region decode, operand select for the shared multiply
	always_comb begin
		ad_sum    = {1'b0, attack_ms} + {1'b0, decay_ms};
		in_attack = elapsed_ms <= {{EXT_W{1'b0}}, attack_ms};
		in_decay  = elapsed_ms <= {{(EXT_W-1){1'b0}}, ad_sum};
		rel_over  = (release_ms == '0) ||
			(release_elapsed_ms >= {{EXT_W{1'b0}}, release_ms});
		setup.rel = releasing;
		if (in_attack) begin
			setup.m      = FULL_LEVEL;
			setup.x      = elapsed_ms[TIME_W-1:0];
			setup.den    = attack_ms;
			setup.forced = (attack_ms == '0);
			setup.fval   = FULL_LEVEL;
			setup.sub    = 1'b0;
		end else if (in_decay) begin
			setup.m      = FULL_LEVEL - sustain_level;
			setup.x      = elapsed_ms[TIME_W-1:0] - attack_ms;
			setup.den    = decay_ms;
			setup.forced = (decay_ms == '0);
			setup.fval   = sustain_level;
			setup.sub    = 1'b1;
		end else if (!releasing) begin
			setup.m      = sustain_level;
			setup.x      = '0;
			setup.den    = release_ms;
			setup.forced = 1'b1;
			setup.fval   = sustain_level;
			setup.sub    = 1'b0;
		end else begin
			setup.m      = sustain_level;
			setup.x      = release_ms - release_elapsed_ms[TIME_W-1:0];
			setup.den    = release_ms;
			setup.forced = rel_over;
			setup.fval   = '0;
			setup.sub    = 1'b0;
		end
	end

	assign prod = PROD_W'(setup_s1.m) * PROD_W'(setup_s1.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			setup_s1       <= setup;
			// quotient fits LEVEL_W bits, so the high part is already below den
			beat_s2.rem    <= prod[PROD_W-1:LEVEL_W];
			beat_s2.nq     <= prod[LEVEL_W-1:0];
			beat_s2.den    <= setup_s1.den;
			beat_s2.forced <= setup_s1.forced;
			beat_s2.fval   <= setup_s1.fval;
			beat_s2.sub    <= setup_s1.sub;
			beat_s2.rel    <= setup_s1.rel;
		end
	end

	assign out_vld  = vld_s2;
	assign out_beat = beat_s2;

endmodule

@@ src/adsr_div_cell.sv @@
module adsr_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  adsr_pkg::div_beat_t in_beat,
	output logic                out_vld,
	output adsr_pkg::div_beat_t out_beat
);
	import adsr_pkg::*;

	logic [TIME_W:0]   trial;
	logic              ge;
	logic [TIME_W:0]   diff;
	div_beat_t         nxt;
	div_beat_t         beat_q;
	logic              vld_q;

	// one restoring step: bring in the next numerator bit, try the divisor
	always_comb begin
		trial   = {in_beat.rem, in_beat.nq[LEVEL_W-1]};
		ge      = trial >= {1'b0, in_beat.den};
		diff    = trial - {1'b0, in_beat.den};
		nxt     = in_beat;
		nxt.rem = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
		nxt.nq  = {in_beat.nq[LEVEL_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			beat_q <= nxt;
		end
	end

	assign out_vld  = vld_q;
	assign out_beat = beat_q;

endmodule

@@ src/adsr_envelope_level_top.sv @@
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    elapsed_ms, releasing, release_elapsed_ms
// out       source     out_valid / out_ready  level, release_done
// cfg       sink       cfg_we (no wait)       cfg_index, cfg_wdata
//
// One beat in and one beat out per cycle when the sink keeps up.
// The pipe is two set-up stages (region decode, multiply),
// eleven divider cells giving one quotient bit each, and the output register.
// arst_n clears the valid bits and loads the register reset values.
// The whole chain advances together; it halts only while a result sits in
// the output register with out_ready low, and in_ready follows that.
module adsr_envelope_level_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [adsr_pkg::ELAPSED_BITS-1:0]   elapsed_ms,
	input  logic                                releasing,
	input  logic [adsr_pkg::ELAPSED_BITS-1:0]   release_elapsed_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [adsr_pkg::LEVEL_W-1:0]        level,
	output logic                                release_done,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import adsr_pkg::*;

	localparam int NCELL = LEVEL_W; // one cell per quotient bit

	logic [TIME_W-1:0]  attack_q;
	logic [TIME_W-1:0]  decay_q;
	logic [LEVEL_W-1:0] sustain_q;
	logic [TIME_W-1:0]  release_q;
	logic [LEVEL_W-1:0] sus_wr;

	logic               en;
	logic               vld [0:NCELL];
	div_beat_t          beat [0:NCELL];
	logic [LEVEL_W-1:0] lvl_nxt;
	logic               out_vld_q;
	logic [LEVEL_W-1:0] level_q;
	logic               done_q;

	// settings; sustain above full scale is clamped on write
	assign sus_wr = (cfg_wdata[LEVEL_W-1:0] > FULL_LEVEL) ? FULL_LEVEL :
		cfg_wdata[LEVEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK:  attack_q  <= cfg_wdata[TIME_W-1:0];
				REG_DECAY:   decay_q   <= cfg_wdata[TIME_W-1:0];
				REG_SUSTAIN: sustain_q <= sus_wr;
				REG_RELEASE: release_q <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: blocked only by an unaccepted result
	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	adsr_prep u_prep (
		.clk                (clk),
		.arst_n             (arst_n),
		.en                 (en),
		.in_vld             (in_valid),
		.elapsed_ms         (elapsed_ms),
		.releasing          (releasing),
		.release_elapsed_ms (release_elapsed_ms),
		.attack_ms          (attack_q),
		.decay_ms           (decay_q),
		.sustain_level      (sustain_q),
		.release_ms         (release_q),
		.out_vld            (vld[0]),
		.out_beat           (beat[0])
	);

	// divider chain, MSB of the quotient first
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		adsr_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld[i]),
			.in_beat  (beat[i]),
			.out_vld  (vld[i+1]),
			.out_beat (beat[i+1])
		);
	end

	// decay counts down from full scale; settled cases bypass the quotient
	always_comb begin
		if (beat[NCELL].forced) begin
			lvl_nxt = beat[NCELL].fval;
		end else if (beat[NCELL].sub) begin
			lvl_nxt = FULL_LEVEL - beat[NCELL].nq;
		end else begin
			lvl_nxt = beat[NCELL].nq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= lvl_nxt;
			done_q  <= beat[NCELL].rel && (lvl_nxt == '0);
		end
	end

	assign out_valid    = out_vld_q;
	assign level        = level_q;
	assign release_done = done_q;

	// checks
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> level_q <= FULL_LEVEL)
		else $error("level above full scale");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && done_q |-> level_q == '0)
		else $error("release_done with non-zero level");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NCELL] && !beat[NCELL].forced |-> beat[NCELL].rem < beat[NCELL].den)
		else $error("divider remainder not below divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[NCELL]) && $stable(vld[0]))
		else $error("chain moved during stall");

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adsr_pkg::*;

	// one result beat: envelope gain and the voice-free flag
	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               release_done;
	} envelope_t;

	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

	logic clk;
	logic arst_n = 1'b0;

	// stimulus side; every input starts at a known value
	logic                    in_valid           = 1'b0;
	logic                    in_ready;
	logic [ELAPSED_BITS-1:0] elapsed_ms         = '0;
	logic                    releasing          = 1'b0;
	logic [ELAPSED_BITS-1:0] release_elapsed_ms = '0;
	logic                    out_valid;
	logic                    out_ready          = 1'b0;
	logic [LEVEL_W-1:0]      level;
	logic                    release_done;
	logic                    cfg_we             = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index          = REG_ATTACK;
	logic [CFG_DATA_W-1:0]   cfg_wdata          = '0;

	// our own copy of the register file, loaded as the block loads its own
	logic [TIME_W-1:0]  cfg_attack  = ATTACK_RST;
	logic [TIME_W-1:0]  cfg_decay   = DECAY_RST;
	logic [LEVEL_W-1:0] cfg_sustain = SUSTAIN_RST;
	logic [TIME_W-1:0]  cfg_release = RELEASE_RST;

	// envelopes still owed by the block, oldest first
	envelope_t expected_levels[$];
	int        mismatches = 0;

	// idling knobs, in percent of cycles
	int unsigned send_idle_pct  = 0;
	int unsigned sink_stall_pct = 0;

	adsr_envelope_level_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.elapsed_ms         (elapsed_ms),
		.releasing          (releasing),
		.release_elapsed_ms (release_elapsed_ms),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.level              (level),
		.release_done       (release_done),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Linear ADSR: attack ramp, decay ramp to sustain, sustain hold, then
	// release ramp to silence. All divides truncate, 64-bit so nothing wraps.
	function automatic envelope_t predict_envelope(input logic [ELAPSED_BITS-1:0] t,
			input logic rel, input logic [ELAPSED_BITS-1:0] rt);
		logic [63:0] full, sus, att, dec, rls, lvl;
		envelope_t res;
		full = 64'(FULL_LEVEL);
		sus  = 64'(cfg_sustain);
		att  = 64'(cfg_attack);
		dec  = 64'(cfg_decay);
		rls  = 64'(cfg_release);
		if (t <= att)
			lvl = (att == 0) ? full : (t * full) / att;
		else if (t <= att + dec)
			lvl = (dec == 0) ? sus : full - ((full - sus) * (t - att)) / dec;
		else if (!rel)
			lvl = sus;	// held note: release time is don't-care
		else if (rls == 0 || rt >= rls)
			lvl = '0;
		else
			lvl = (sus * (rls - rt)) / rls;
		res.level        = lvl[LEVEL_W-1:0];
		res.release_done = rel && (lvl == 0);
		return res;
	endfunction

	// Inputs only move on the rising edge, so the falling edge sees exactly
	// what the next rising edge will take. Sampling here keeps the monitor
	// clear of any ordering within the edge's time step.
	always @(negedge clk) begin
		envelope_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_levels.push_back(predict_envelope(elapsed_ms, releasing,
						release_elapsed_ms));
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					$error("unexpected result beat: level %0d, release_done %0b",
							level, release_done);
					mismatches++;
				end else begin
					want = expected_levels.pop_front();
					if (level !== want.level) begin
						$error("level: expected %0d, got %0d", want.level, level);
						mismatches++;
					end
					if (release_done !== want.release_done) begin
						$error("release_done: expected %0b, got %0b",
								want.release_done, release_done);
						mismatches++;
					end
				end
			end
			// register writes land on the coming edge
			if (cfg_we) begin
				case (cfg_index)
					REG_ATTACK:  cfg_attack  = cfg_wdata[TIME_W-1:0];
					REG_DECAY:   cfg_decay   = cfg_wdata[TIME_W-1:0];
					// only the low bits are kept, then clipped to full scale
					REG_SUSTAIN: cfg_sustain = (cfg_wdata[LEVEL_W-1:0] > FULL_LEVEL) ?
							FULL_LEVEL : cfg_wdata[LEVEL_W-1:0];
					REG_RELEASE: cfg_release = cfg_wdata[TIME_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Offer one beat, with random idle cycles first, and return at the edge
	// that takes it. in_valid is left high so a following beat goes back to back.
	task automatic send_envelope_beat(input logic [ELAPSED_BITS-1:0] t, input logic rel,
			input logic [ELAPSED_BITS-1:0] rt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid           <= 1'b1;
		elapsed_ms         <= t;
		releasing          <= rel;
		release_elapsed_ms <= rt;
		// in_ready cannot move between the falling and the rising edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Stop sending and wait for every owed envelope; one result per beat,
	// so an empty queue means an empty pipe.
	task automatic wait_levels_settled();
		in_valid <= 1'b0;
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// full register load, only ever with the block idle
	task automatic load_envelope_shape(input logic [CFG_DATA_W-1:0] att,
			input logic [CFG_DATA_W-1:0] dec, input logic [CFG_DATA_W-1:0] sus,
			input logic [CFG_DATA_W-1:0] rls);
		wait_levels_settled();
		put_reg(REG_ATTACK, att);
		put_reg(REG_DECAY, dec);
		put_reg(REG_SUSTAIN, sus);
		put_reg(REG_RELEASE, rls);
		cfg_we <= 1'b0;
	endtask

	// Reset shape (115/200/1020/540): region boundaries, saturated times,
	// release arriving mid-attack and mid-decay, release time while held.
	task automatic test_reset_shape();
		send_envelope_beat('0, 1'b0, '0);
		send_envelope_beat(20'd57, 1'b0, '0);
		send_envelope_beat(20'd115, 1'b0, '0);
		send_envelope_beat(20'd215, 1'b0, '0);
		send_envelope_beat(ELAPSED_MAX, 1'b0, ELAPSED_MAX);
		send_envelope_beat(ELAPSED_MAX, 1'b1, '0);
		send_envelope_beat(ELAPSED_MAX, 1'b1, 20'd539);
		send_envelope_beat(ELAPSED_MAX, 1'b1, 20'd540);
		send_envelope_beat(ELAPSED_MAX, 1'b1, ELAPSED_MAX);
		send_envelope_beat(20'd50, 1'b1, 20'd1000);
		send_envelope_beat('0, 1'b1, ELAPSED_MAX);
		send_envelope_beat(20'd150, 1'b1, 20'd5);
	endtask

	// Zero and maximum durations, sustain clipping and the dropped top bit.
	task automatic test_duration_extremes();
		// everything instant; 0xFFF keeps 0x7FF, which clips to full scale
		load_envelope_shape('0, '0, 12'hFFF, '0);
		send_envelope_beat('0, 1'b0, '0);
		send_envelope_beat(20'd1, 1'b0, 20'd77);
		send_envelope_beat(20'd1, 1'b1, '0);
		// longest ramps, silent sustain
		load_envelope_shape(12'd4095, 12'd4095, '0, 12'd4095);
		send_envelope_beat(20'd1, 1'b0, '0);
		send_envelope_beat(20'd4095, 1'b0, '0);
		send_envelope_beat(20'd4096, 1'b1, '0);
		send_envelope_beat(20'd8190, 1'b0, '0);
		send_envelope_beat(20'd8191, 1'b0, '0);
		send_envelope_beat(20'd8191, 1'b1, '0);
		// just above full scale is clipped
		load_envelope_shape('0, 12'd1, 12'd1025, 12'd4095);
		send_envelope_beat('0, 1'b1, ELAPSED_MAX);
		send_envelope_beat(20'd1, 1'b1, '0);
		send_envelope_beat(20'd2, 1'b1, 20'd4094);
		// bit 11 of the sustain write is lost: 2048 reads back as silence
		load_envelope_shape(12'd3, 12'd2, 12'd2048, 12'd1);
		send_envelope_beat(20'd9, 1'b0, '0);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_duration();
		case ($urandom_range(5))
			0:       return '0;
			1:       return 12'd4095;
			2, 3:    return CFG_DATA_W'($urandom_range(24, 1));
			default: return CFG_DATA_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_sustain();
		case ($urandom_range(4))
			0:       return '0;
			1:       return CFG_DATA_W'(FULL_LEVEL);
			2:       return CFG_DATA_W'($urandom_range(4095, 1025));
			default: return CFG_DATA_W'($urandom_range(1024));
		endcase
	endfunction

	// Four idling phases; each one runs a dozen random shapes. Every shape
	// change waits for the pipe to empty, which also covers the sender
	// holding off until all results are home.
	task automatic test_random_envelopes();
		int unsigned att, dec, rls;
		logic [ELAPSED_BITS-1:0] t, rt;
		logic rel;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 75; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 75; end
				default: begin send_idle_pct = 6; sink_stall_pct = 6; end
			endcase
			for (int shape = 0; shape < 12; shape++) begin
				att = 32'(pick_duration());
				dec = 32'(pick_duration());
				rls = 32'(pick_duration());
				load_envelope_shape(CFG_DATA_W'(att), CFG_DATA_W'(dec), pick_sustain(),
						CFG_DATA_W'(rls));
				for (int n = 0; n < 39; n++) begin
					// aim most times at the ramps and just past them
					case ($urandom_range(9))
						0, 1, 2: t = ELAPSED_BITS'($urandom_range(att));
						3, 4:    t = ELAPSED_BITS'((dec == 0) ? att :
								att + $urandom_range(dec, 1));
						9:       t = ELAPSED_BITS'($urandom_range(ELAPSED_MAX));
						default: t = ELAPSED_BITS'(att + dec + 1 + $urandom_range(2000));
					endcase
					rel = ($urandom_range(3) != 0);
					rt  = ($urandom_range(3) == 0) ?
							ELAPSED_BITS'($urandom_range(ELAPSED_MAX)) :
							ELAPSED_BITS'($urandom_range(rls + 2));
					send_envelope_beat(t, rel, rt);
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_shape();
		test_duration_extremes();
		test_random_envelopes();
		wait_levels_settled();
		// room for any stray beat still in the pipe
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
